FILE: rtl/core/pfdm_pkg.sv
// Shared types and constants for the PWM frequency and duty meter.
`default_nettype none

package pfdm_pkg;

  localparam int TIME_BITS = 48;
  localparam int FREQ_W    = 20;
  localparam int DUTY_W    = 7;
  localparam int MS_W      = 39;
  localparam int CFG_W     = 32;
  localparam int STEP_W    = $clog2(TIME_BITS + 1);

  localparam int IN_DATA_W  = ((1 + TIME_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = FREQ_W + DUTY_W + MS_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // millisecond conversion: radix-256 long division, reciprocal per digit
  localparam int MS_DIGIT_W = 8;
  localparam int MS_REM_W   = 10;
  localparam int MS_V_W     = MS_REM_W + MS_DIGIT_W;
  localparam int MS_RECIP_W = 19;
  localparam int MS_SHIFT   = 28;
  localparam int MS_PROD_W  = MS_V_W + MS_RECIP_W;
  localparam int MS_STEPS   = (TIME_BITS + MS_DIGIT_W - 1) / MS_DIGIT_W;
  localparam int MS_DIV_W   = MS_STEPS * MS_DIGIT_W;
  localparam int MS_CNT_W   = $clog2(MS_STEPS + 1);

  localparam logic [FREQ_W-1:0]     FREQ_NUM    = FREQ_W'(1000000);
  localparam logic [DUTY_W-1:0]     DUTY_FULL   = DUTY_W'(100);
  localparam logic [MS_REM_W-1:0]   US_PER_MS   = MS_REM_W'(1000);
  localparam logic [CFG_W-1:0]      FADE_RESET  = CFG_W'(1000000);
  // ceil(2^28 / 1000), exact for every digit step value below 256000
  localparam logic [MS_RECIP_W-1:0] MS_RECIP    = MS_RECIP_W'(268436);

  typedef enum logic [1:0] {
    OP_RISE,
    OP_OTHER,
    OP_REPORT
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [TIME_BITS-1:0] time_us;
  } queue_entry_t;

  typedef struct packed {
    logic                 start;
    logic [TIME_BITS-1:0] rem_init;
    logic [TIME_BITS-1:0] bits;
    logic [STEP_W-1:0]    steps;
    logic [TIME_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [TIME_BITS-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/pwm_frequency_duty_meter.sv
// Top level of the PWM frequency and duty meter.
//
//  channel  direction  handshake           payload
//  s_*      in         s_tvalid/s_tready   tdata: pin_level, time_us; tuser: kind
//  m_*      out        m_tvalid/m_tready   tdata: freq_hz, duty_pct, last_edge_ms
//  apb      in         psel/penable/pready fade_out_us at address 0
//
// An edge word passes S_CALC, S_FREQ, S_DUTY, S_MS, S_MS_WAIT and S_OUT
// (S_DUTY is skipped when duty saturates, both divides at zero period): the
// bit-serial divider takes 20 steps for frequency and 7 for duty, the
// millisecond conversion 6 radix-256 steps, with hand-off states between them.
// A report word goes from S_IDLE to S_OUT. A two-word queue takes input while
// the back end works; the result register holds a word until taken and stalls
// the back end. Synchronous reset clears state; fade_out_us resets to 1000000.
`default_nettype none

module pwm_frequency_duty_meter (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [pfdm_pkg::IN_DATA_W-1:0]   s_tdata,  // pin_level, time_us
  input  wire logic                             s_tuser,  // kind
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [pfdm_pkg::OUT_DATA_W-1:0]       m_tdata,  // freq_hz, duty_pct, last_edge_ms
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [1:0]                       paddr,
  input  wire logic [pfdm_pkg::CFG_W-1:0]       pwdata,
  output logic [pfdm_pkg::CFG_W-1:0]            prdata,
  output logic                                  pready
);
  import pfdm_pkg::*;

  localparam logic [1:0] ADDR_FADE_OUT = 2'd0;

  logic [CFG_W-1:0]  fade_out_us;
  logic              q_valid;
  queue_entry_t      q_entry;
  logic              q_pop;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [FREQ_W-1:0] freq_hz;
  logic [DUTY_W-1:0] duty_pct;
  logic [MS_W-1:0]   last_edge_ms;

  assign pready  = 1'b1;
  assign prdata  = (paddr == ADDR_FADE_OUT) ? fade_out_us : '0;
  assign m_tdata = {(OUT_DATA_W-OUT_BITS)'(0), last_edge_ms, duty_pct, freq_hz};

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_out_us <= FADE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_FADE_OUT)) begin
      fade_out_us <= pwdata;
    end
  end

  pfdm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  pfdm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pfdm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop),
    .fade_out_us  (fade_out_us),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .freq_hz      (freq_hz),
    .duty_pct     (duty_pct),
    .last_edge_ms (last_edge_ms)
  );

endmodule

`default_nettype wire

FILE: rtl/core/pfdm_front.sv
// Input side: accepts words, classifies edges and queues them for the back end.
`default_nettype none

module pfdm_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [pfdm_pkg::IN_DATA_W-1:0]  s_tdata,  // pin_level, time_us
  input  wire logic                            s_tuser,  // kind
  output logic                                 q_valid,
  output pfdm_pkg::queue_entry_t               q_entry,
  input  wire logic                            q_pop
);
  import pfdm_pkg::*;

  queue_entry_t fifo [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         prev_level;
  logic         push;
  logic         pin_level;
  queue_entry_t entry_in;

  assign s_tready  = (count != 2'd2);
  assign push      = s_tvalid && s_tready;
  assign pin_level = s_tdata[0];
  assign q_valid   = (count != 2'd0);
  assign q_entry   = fifo[rd_ptr];

  always_comb begin
    entry_in.time_us = s_tdata[TIME_BITS:1];
    if (s_tuser) begin
      entry_in.op = OP_REPORT;
    end else if (pin_level && !prev_level) begin
      entry_in.op = OP_RISE;
    end else begin
      entry_in.op = OP_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
      count      <= 2'd0;
      prev_level <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
        if (!s_tuser) begin
          prev_level <= pin_level;
        end
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pfdm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module pfdm_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pfdm_pkg::div_req_t req,
  output pfdm_pkg::div_rsp_t     rsp
);
  import pfdm_pkg::*;

  logic                 busy;
  logic [STEP_W-1:0]    cnt;
  logic [TIME_BITS-1:0] rem;
  logic [TIME_BITS-1:0] bits;
  logic [TIME_BITS-1:0] quot;
  logic [TIME_BITS-1:0] divisor;
  logic                 done;
  logic [TIME_BITS:0]   rem_shift;
  logic                 ge;
  logic [TIME_BITS:0]   rem_sub;

  assign rem_shift = {rem, bits[TIME_BITS-1]};
  assign ge        = rem_shift >= {1'b0, divisor};
  assign rem_sub   = rem_shift - {1'b0, divisor};
  assign rsp.done  = done;
  assign rsp.quot  = quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= req.steps;
        rem     <= req.rem_init;
        bits    <= req.bits;
        divisor <= req.divisor;
        quot    <= '0;
      end else if (busy) begin
        rem  <= ge ? rem_sub[TIME_BITS-1:0] : rem_shift[TIME_BITS-1:0];
        bits <= {bits[TIME_BITS-2:0], 1'b0};
        quot <= {quot[TIME_BITS-2:0], ge};
        cnt  <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pfdm_back.sv
// Back end: measurement state, divide sequencing and the result register.
`default_nettype none

module pfdm_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire pfdm_pkg::queue_entry_t        q_entry,
  output logic                               q_pop,
  input  wire logic [pfdm_pkg::CFG_W-1:0]    fade_out_us,
  output pfdm_pkg::div_req_t                 div_req,
  input  wire pfdm_pkg::div_rsp_t            div_rsp,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [pfdm_pkg::FREQ_W-1:0]        freq_hz,
  output logic [pfdm_pkg::DUTY_W-1:0]        duty_pct,
  output logic [pfdm_pkg::MS_W-1:0]          last_edge_ms
);
  import pfdm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_FREQ,
    S_DUTY,
    S_MS,
    S_MS_WAIT,
    S_OUT
  } state_t;

  state_t               state;
  logic [TIME_BITS-1:0] rise_time;
  logic [TIME_BITS-1:0] period_us;
  logic [TIME_BITS-1:0] high_us;
  logic [TIME_BITS-1:0] last_edge_us;
  logic [FREQ_W-1:0]    freq_value;
  logic [DUTY_W-1:0]    duty_value;
  logic [MS_W-1:0]      ms_value;

  logic [TIME_BITS-1:0] idle_us;
  logic [TIME_BITS+6:0] high_x100;
  logic                 saturated;

  logic [MS_DIV_W-1:0]   ms_dividend;
  logic [MS_REM_W-1:0]   ms_rem;
  logic [MS_DIV_W-1:0]   ms_quot;
  logic [MS_CNT_W-1:0]   ms_cnt;
  logic [MS_V_W-1:0]     ms_v;
  logic [MS_PROD_W-1:0]  ms_prod;
  logic [MS_DIGIT_W-1:0] ms_digit;
  logic [MS_REM_W-1:0]   ms_rem_next;
  logic [MS_DIV_W-1:0]   ms_quot_next;

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign idle_us   = q_entry.time_us - last_edge_us;
  assign saturated = (high_us >= period_us);
  assign high_x100 = {1'b0, high_us, 6'b0} + {2'b0, high_us, 5'b0} + {5'b0, high_us, 2'b0};

  // one base-256 digit of last_edge_us / 1000 per cycle
  assign ms_v         = {ms_rem, ms_dividend[MS_DIV_W-1 -: MS_DIGIT_W]};
  assign ms_prod      = MS_PROD_W'(ms_v) * MS_PROD_W'(MS_RECIP);
  assign ms_digit     = ms_prod[MS_SHIFT +: MS_DIGIT_W];
  assign ms_rem_next  = MS_REM_W'(ms_v - MS_V_W'(ms_digit) * MS_V_W'(US_PER_MS));
  assign ms_quot_next = {ms_quot[MS_DIV_W-MS_DIGIT_W-1:0], ms_digit};

  always_comb begin
    div_req.start    = 1'b0;
    div_req.rem_init = '0;
    div_req.bits     = '0;
    div_req.steps    = STEP_W'(TIME_BITS);
    div_req.divisor  = '0;
    unique case (state)
      S_CALC: begin
        div_req.start   = (period_us != '0);
        div_req.bits    = {FREQ_NUM, (TIME_BITS-FREQ_W)'(0)};
        div_req.steps   = STEP_W'(FREQ_W);
        div_req.divisor = period_us;
      end
      S_FREQ: begin
        div_req.start    = div_rsp.done && !saturated;
        div_req.rem_init = high_x100[TIME_BITS+6:7];
        div_req.bits     = {high_x100[6:0], (TIME_BITS-7)'(0)};
        div_req.steps    = STEP_W'(DUTY_W);
        div_req.divisor  = period_us;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rise_time    <= '0;
      period_us    <= '0;
      high_us      <= '0;
      last_edge_us <= '0;
      freq_value   <= '0;
      duty_value   <= '0;
      ms_value     <= '0;
      ms_dividend  <= '0;
      ms_rem       <= '0;
      ms_quot      <= '0;
      ms_cnt       <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            unique case (q_entry.op)
              OP_RISE: begin
                period_us    <= q_entry.time_us - rise_time;
                rise_time    <= q_entry.time_us;
                last_edge_us <= q_entry.time_us;
                state        <= S_CALC;
              end
              OP_OTHER: begin
                high_us      <= q_entry.time_us - rise_time;
                last_edge_us <= q_entry.time_us;
                state        <= S_CALC;
              end
              OP_REPORT: begin
                if (idle_us > TIME_BITS'(fade_out_us)) begin
                  freq_value <= '0;
                  duty_value <= '0;
                end
                state <= S_OUT;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_CALC: begin
          if (period_us == '0) begin
            freq_value <= '0;
            duty_value <= '0;
            state      <= S_MS;
          end else begin
            state <= S_FREQ;
          end
        end
        S_FREQ: begin
          if (div_rsp.done) begin
            freq_value <= FREQ_W'(div_rsp.quot);
            if (saturated) begin
              duty_value <= DUTY_FULL;
              state      <= S_MS;
            end else begin
              state <= S_DUTY;
            end
          end
        end
        S_DUTY: begin
          if (div_rsp.done) begin
            duty_value <= DUTY_W'(div_rsp.quot);
            state      <= S_MS;
          end
        end
        S_MS: begin
          ms_dividend <= MS_DIV_W'(last_edge_us);
          ms_rem      <= '0;
          ms_quot     <= '0;
          ms_cnt      <= MS_CNT_W'(MS_STEPS);
          state       <= S_MS_WAIT;
        end
        S_MS_WAIT: begin
          ms_dividend <= ms_dividend << MS_DIGIT_W;
          ms_rem      <= ms_rem_next;
          ms_quot     <= ms_quot_next;
          ms_cnt      <= ms_cnt - MS_CNT_W'(1);
          if (ms_cnt == MS_CNT_W'(1)) begin
            ms_value <= MS_W'(ms_quot_next);
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            freq_hz      <= freq_value;
            duty_pct     <= duty_value;
            last_edge_ms <= ms_value;
            m_tvalid     <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
